### rtl/core/sacsc_pkg.sv
// Package for the second-chance set-associative cache unit.
// Holds geometry constants, request and response word types, the lookup
// result struct and the controller state encoding. No dependencies.
package sacsc_pkg;

    localparam int SETS           = 8;
    localparam int WAYS           = 8;
    localparam int WORDS_PER_LINE = 16;
    localparam int MEM_WORDS      = 65536;

    localparam int ADDR_W = 18;
    localparam int DATA_W = 32;
    localparam int WA_W   = $clog2(MEM_WORDS);
    localparam int OFF_W  = $clog2(WORDS_PER_LINE);
    localparam int SET_W  = $clog2(SETS);
    localparam int WAY_W  = $clog2(WAYS);
    localparam int TAG_W  = WA_W - OFF_W - SET_W;
    localparam int LINE_AW = SET_W + WAY_W + OFF_W;
    localparam int CNT_W  = OFF_W + 1;

    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              hit;
        logic              bypassed;
    } rsp_t;

    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

    typedef struct packed {
        logic             hit;
        logic [WAY_W-1:0] hit_way;
        logic             inv_found;
        logic [WAY_W-1:0] inv_way;
        logic             scan_found;
        logic [WAY_W-1:0] scan_way;
        logic [WAYS-1:0]  clear_mask;
    } lookup_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_HIT_READ,
        ST_BYP_READ,
        ST_WBACK,
        ST_FILL
    } state_t;

endpackage

### rtl/core/sacsc_victim.sv
// Way search for one set: tag match, first invalid way and second-chance scan.
// Depends on sacsc_pkg.
module sacsc_victim (
    input  sacsc_pkg::tag_row_t               tag_row,
    input  logic [sacsc_pkg::TAG_W-1:0]       tag,
    input  logic [sacsc_pkg::WAYS-1:0]        valid,
    input  logic [sacsc_pkg::WAYS-1:0]        sc,
    input  logic [sacsc_pkg::WAY_W-1:0]       ptr,
    output sacsc_pkg::lookup_t                lk
);
    import sacsc_pkg::*;

    always_comb
    begin
        logic [WAY_W-1:0] p;
        lk = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (valid[w] && tag_row[w] == tag)
            begin
                lk.hit     = 1'b1;
                lk.hit_way = WAY_W'(w);
            end
            if (!valid[w])
            begin
                lk.inv_found = 1'b1;
                lk.inv_way   = WAY_W'(w);
            end
        end
        for (int n = 0; n < WAYS; n++)
        begin
            p = ptr + WAY_W'(n);
            if (!lk.scan_found)
            begin
                if (!sc[p])
                begin
                    lk.scan_found = 1'b1;
                    lk.scan_way   = p;
                end
                else
                begin
                    lk.clear_mask[p] = 1'b1;
                end
            end
        end
    end

endmodule

### rtl/core/set_assoc_cache_second_chance_unit.sv
// Second-chance write-back cache with its own backing word memory.
// Hit or bypass writes finish in LOOKUP; hit or bypass reads add HIT_READ or BYP_READ;
// a miss writes a dirty victim back, then fills the line (one memory word per cycle).
// One word is in flight at a time; busy stays high until done.
// After reset the backing memory is cleared with busy high.
// Depends on sacsc_pkg and sacsc_victim.
module set_assoc_cache_second_chance_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  sacsc_pkg::req_t   req,
    output logic              busy,
    output logic              done,
    output sacsc_pkg::rsp_t   rsp
);
    import sacsc_pkg::*;

    state_t                      state_reg, state_next;
    req_t                        req_reg, req_next;
    rsp_t                        rsp_reg, rsp_next;
    logic                        done_reg, done_next;
    logic [WAY_W-1:0]            way_reg, way_next;
    logic [WAY_W-1:0]            ptr_reg, ptr_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [WA_W-1:0]             clr_reg, clr_next;
    logic [SETS-1:0][WAYS-1:0]   valid_reg, valid_next;
    logic [SETS-1:0][WAYS-1:0]   dirty_reg, dirty_next;
    logic [SETS-1:0][WAYS-1:0]   sc_reg, sc_next;

    tag_row_t                    tag_mem [SETS];
    tag_row_t                    tag_q;
    tag_row_t                    tag_wdata;
    logic                        tag_re, tag_we;
    logic [SET_W-1:0]            tag_raddr;

    logic [DATA_W-1:0]           line_mem [SETS*WAYS*WORDS_PER_LINE];
    logic [DATA_W-1:0]           line_q, line_wdata;
    logic                        line_re, line_we;
    logic [LINE_AW-1:0]          line_addr;

    logic [DATA_W-1:0]           back_mem [MEM_WORDS];
    logic [DATA_W-1:0]           mem_q, mem_wdata;
    logic                        mem_re, mem_we;
    logic [WA_W-1:0]             mem_addr;

    logic [WA_W-1:0]             wa;
    logic [OFF_W-1:0]            word;
    logic [SET_W-1:0]            set;
    logic [TAG_W-1:0]            tag;
    logic [OFF_W-1:0]            idx;
    logic [WAY_W-1:0]            victim;
    logic                        take_victim;
    lookup_t                     lk;

    assign wa        = req_reg.address[ADDR_W-1:2];
    assign word      = wa[OFF_W-1:0];
    assign set       = wa[OFF_W +: SET_W];
    assign tag       = wa[WA_W-1 -: TAG_W];
    assign idx       = cnt_reg[OFF_W-1:0] - OFF_W'(1);
    assign tag_raddr = req.address[2 + OFF_W +: SET_W];

    sacsc_victim u_victim (
        .tag_row (tag_q),
        .tag     (tag),
        .valid   (valid_reg[set]),
        .sc      (sc_reg[set]),
        .ptr     (ptr_reg),
        .lk      (lk)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            done_reg  <= 1'b0;
            ptr_reg   <= '0;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            valid_reg <= '0;
            dirty_reg <= '0;
            sc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            ptr_reg   <= ptr_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            sc_reg    <= sc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        way_reg <= way_next;
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[set] <= tag_wdata;
        end
        if (tag_re)
        begin
            tag_q <= tag_mem[tag_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_addr] <= line_wdata;
        end
        if (line_re)
        begin
            line_q <= line_mem[line_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            back_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= back_mem[mem_addr];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        req_next    = req_reg;
        rsp_next    = rsp_reg;
        done_next   = 1'b0;
        way_next    = way_reg;
        ptr_next    = ptr_reg;
        cnt_next    = cnt_reg;
        clr_next    = clr_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        sc_next     = sc_reg;
        tag_re      = 1'b0;
        tag_we      = 1'b0;
        tag_wdata   = tag_q;
        line_re     = 1'b0;
        line_we     = 1'b0;
        line_addr   = '0;
        line_wdata  = '0;
        mem_re      = 1'b0;
        mem_we      = 1'b0;
        mem_addr    = '0;
        mem_wdata   = '0;
        victim      = lk.inv_way;
        take_victim = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = clr_reg;
                clr_next = clr_reg + WA_W'(1);
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next   = req;
                    tag_re     = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                rsp_next = '0;
                if (lk.hit)
                begin
                    sc_next[set][lk.hit_way] = 1'b1;
                    line_addr = {set, lk.hit_way, word};
                    rsp_next.hit = 1'b1;
                    if (req_reg.mode == MODE_WRITE)
                    begin
                        line_we    = 1'b1;
                        line_wdata = req_reg.write_data;
                        dirty_next[set][lk.hit_way] = 1'b1;
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        line_re    = 1'b1;
                        state_next = ST_HIT_READ;
                    end
                end
                else if (lk.inv_found)
                begin
                    take_victim = 1'b1;
                end
                else
                begin
                    sc_next[set] = sc_reg[set] & ~lk.clear_mask;
                    if (lk.scan_found)
                    begin
                        victim      = lk.scan_way;
                        ptr_next    = lk.scan_way + WAY_W'(1);
                        take_victim = 1'b1;
                    end
                    else
                    begin
                        mem_addr = wa;
                        rsp_next.bypassed = 1'b1;
                        if (req_reg.mode == MODE_WRITE)
                        begin
                            mem_we     = 1'b1;
                            mem_wdata  = req_reg.write_data;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            mem_re     = 1'b1;
                            state_next = ST_BYP_READ;
                        end
                    end
                end
                if (take_victim)
                begin
                    way_next   = victim;
                    cnt_next   = '0;
                    state_next = dirty_reg[set][victim] ? ST_WBACK : ST_FILL;
                end
            end
            ST_HIT_READ:
            begin
                rsp_next.read_data = line_q;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BYP_READ:
            begin
                rsp_next.read_data = mem_q;
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_WBACK:
            begin
                if (!cnt_reg[OFF_W])
                begin
                    line_re   = 1'b1;
                    line_addr = {set, way_reg, cnt_reg[OFF_W-1:0]};
                end
                if (cnt_reg != '0)
                begin
                    mem_we    = 1'b1;
                    mem_addr  = {tag_q[way_reg], set, idx};
                    mem_wdata = line_q;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[OFF_W])
                begin
                    cnt_next   = '0;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (!cnt_reg[OFF_W])
                begin
                    mem_re   = 1'b1;
                    mem_addr = {tag, set, cnt_reg[OFF_W-1:0]};
                end
                if (cnt_reg != '0)
                begin
                    line_we    = 1'b1;
                    line_addr  = {set, way_reg, idx};
                    line_wdata = mem_q;
                    if (idx == word)
                    begin
                        if (req_reg.mode == MODE_WRITE)
                        begin
                            line_wdata = req_reg.write_data;
                        end
                        else
                        begin
                            rsp_next.read_data = mem_q;
                        end
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg[OFF_W])
                begin
                    cnt_next  = '0;
                    tag_we    = 1'b1;
                    tag_wdata[way_reg] = tag;
                    valid_next[set][way_reg] = 1'b1;
                    dirty_next[set][way_reg] = req_reg.mode;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_hit_not_bypass: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(rsp_reg.hit && rsp_reg.bypassed))
        else $error("hit and bypass reported together");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("done strobe while controller still busy");

    a_valid_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(valid_reg) & ~valid_reg) == '0)
        else $error("a valid line was dropped");

endmodule
